### design/cle_pkg.sv
`timescale 1ns / 1ps
package cle_pkg;

   // Line store geometry
   localparam int LINE_LEN    = 32;
   localparam int LINE_ADDR_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int COUNT_W     = 6;
   localparam int BYTE_W      = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Terminal characters
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
   localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_ERASE = 2'd1,
      CMD_LINE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

### design/cle_req_if.sv
`timescale 1ns / 1ps
interface cle_req_if import cle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### design/cle_rsp_if.sv
`timescale 1ns / 1ps
interface cle_rsp_if import cle_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               to_terminal;
   logic               line_end;
   logic [COUNT_W-1:0] line_length;
   logic               dropped;
   logic               last;

   modport source (output valid, output out_byte, output to_terminal, output line_end,
                   output line_length, output dropped, output last, input ready);
   modport sink (input valid, input out_byte, input to_terminal, input line_end,
                 input line_length, input dropped, input last, output ready);
endinterface

### design/cle_front.sv
`timescale 1ns / 1ps
module cle_front import cle_pkg::*; (
   cle_req_if.sink req_ch,
   input  logic    queue_ready,
   output logic    push,
   output cmd_type push_cmd
);

   // Fold CR into LF, then sort the word into a command
   always_comb begin
      push_cmd.data = req_ch.rx_byte;
      unique case (req_ch.rx_byte) inside
         CH_CR, CH_LF: push_cmd.kind = CMD_LINE;
         CH_BS:        push_cmd.kind = CMD_ERASE;
         default:      push_cmd.kind = CMD_STORE;
      endcase
   end

   assign req_ch.ready = queue_ready;
   assign push         = req_ch.valid & queue_ready;

endmodule

### design/cle_queue.sv
`timescale 1ns / 1ps
module cle_queue import cle_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        push_cmd,
   output logic           queue_ready,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign queue_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.cmd    = entry_ff[rd_ptr_ff];
   assign do_pop      = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/cle_back.sv
`timescale 1ns / 1ps
module cle_back import cle_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   cle_rsp_if.source      rsp_ch
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BS_SP = 3'd1;
   localparam logic [2:0] ST_BS_BS = 3'd2;
   localparam logic [2:0] ST_LF    = 3'd3;
   localparam logic [2:0] ST_DATA  = 3'd4;
   localparam logic [2:0] ST_END   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]  line_mem [LINE_LEN];
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               wr_en;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               to_terminal_ff, to_terminal_in;
   logic               line_end_ff, line_end_in;
   logic [COUNT_W-1:0] line_length_ff, line_length_in;
   logic               dropped_ff, dropped_in;
   logic               last_ff, last_in;
   logic               load;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      pop            = 1'b0;
      load           = 1'b0;
      wr_en          = 1'b0;
      out_byte_in    = '0;
      to_terminal_in = 1'b0;
      line_end_in    = 1'b0;
      line_length_in = '0;
      dropped_in     = 1'b0;
      last_in        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               unique case (head.cmd.kind)
                  CMD_STORE: begin
                     load    = 1'b1;
                     last_in = 1'b1;
                     if (fill_ff < COUNT_W'(LINE_LEN)) begin
                        wr_en          = 1'b1;
                        out_byte_in    = head.cmd.data;
                        to_terminal_in = 1'b1;
                        fill_in        = fill_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  CMD_ERASE: begin
                     // drop an erase on an empty line
                     if (fill_ff != '0) begin
                        load           = 1'b1;
                        out_byte_in    = CH_BS;
                        to_terminal_in = 1'b1;
                        state_in       = ST_BS_SP;
                     end
                  end
                  CMD_LINE: begin
                     load           = 1'b1;
                     out_byte_in    = CH_CR;
                     to_terminal_in = 1'b1;
                     state_in       = ST_LF;
                  end
                  default: ;
               endcase
            end
         end
         ST_BS_SP: begin
            if (out_free) begin
               load           = 1'b1;
               out_byte_in    = CH_SP;
               to_terminal_in = 1'b1;
               state_in       = ST_BS_BS;
            end
         end
         ST_BS_BS: begin
            if (out_free) begin
               load           = 1'b1;
               out_byte_in    = CH_BS;
               to_terminal_in = 1'b1;
               last_in        = 1'b1;
               fill_in        = fill_ff - 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LF: begin
            if (out_free) begin
               load           = 1'b1;
               out_byte_in    = CH_LF;
               to_terminal_in = 1'b1;
               idx_in         = '0;
               state_in       = (fill_ff == '0) ? ST_END : ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = rd_data_ff;
               idx_in      = idx_ff + 1'b1;
               if (idx_in == fill_ff) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               load           = 1'b1;
               line_end_in    = 1'b1;
               line_length_in = fill_ff;
               last_in        = 1'b1;
               fill_in        = '0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff    <= out_byte_in;
         to_terminal_ff <= to_terminal_in;
         line_end_ff    <= line_end_in;
         line_length_ff <= line_length_in;
         dropped_ff     <= dropped_in;
         last_ff        <= last_in;
      end
   end

   // Line store: read one entry ahead so the byte is ready in ST_DATA
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[LINE_ADDR_W-1:0]] <= head.cmd.data;
      end
      rd_data_ff <= line_mem[idx_in[LINE_ADDR_W-1:0]];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = out_byte_ff;
   assign rsp_ch.to_terminal = to_terminal_ff;
   assign rsp_ch.line_end    = line_end_ff;
   assign rsp_ch.line_length = line_length_ff;
   assign rsp_ch.dropped     = dropped_ff;
   assign rsp_ch.last        = last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(LINE_LEN))
      else $error("line fill count above capacity");

   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> idx_ff < fill_ff)
      else $error("line readout index past fill count");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      load && dropped_in |-> fill_ff == COUNT_W'(LINE_LEN))
      else $error("byte dropped while line store had room");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      load && line_end_in |=> fill_ff == '0 && state_ff == ST_IDLE)
      else $error("line not cleared after end record");
`endif

endmodule

### design/console_line_editor.sv
// A result word is registered in the command queue, then in the back-end output register.
// Throughput: one result word per cycle unless ready stalls the output; a store or drop gives
// one word, a byte erase BS, SP, BS, a line end CR, LF, each stored byte and an end record.
// The two-entry command queue keeps accepting input words while the back end works, until full.
// Reset (synchronous, active high) empties the line and the queue; the line store is not cleared.
`timescale 1ns / 1ps
module console_line_editor import cle_pkg::*; (
   input logic       clock,
   input logic       reset,
   cle_req_if.sink   req_ch,
   cle_rsp_if.source rsp_ch
);

   logic           queue_ready;
   logic           push;
   cmd_type        push_cmd;
   queue_head_type head;
   logic           pop;

   // Front end: classify each terminal word (CR folds into LF)
   cle_front u_front (
      .req_ch      (req_ch),
      .queue_ready (queue_ready),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Decouple the classifier from the echo/readout sequencer
   cle_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_ready (queue_ready),
      .head        (head),
      .pop         (pop)
   );

   // Back end: own the line store, echo, erase and hand out finished lines
   cle_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
